// File: rtl/core/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared widths, constants, types and lookup functions for the MJD to
// calendar date and time converter.
// ----------------------------------------------------------------------------
package mdc_pkg;

  // Port field widths
  localparam int DAY_W     = 24;
  localparam int FRAC_IN_W = 40;
  localparam int YEAR_W    = 16;
  localparam int MONTH_W   = 4;
  localparam int DOM_W     = 5;
  localparam int DOY_W     = 9;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int NS_W      = 30;

  // Binary fraction of a day actually used (low bits of the fraction field)
  localparam int FRAC_BITS = 40;

  // Pipeline depth; valid bits and stage enables are indexed 0..NSTAGE-1
  localparam int NSTAGE    = 13;
  // Stage index at which the time-of-day path is complete
  localparam int TIME_LAST = 2;

  // Date path: Julian day number and Gregorian switch
  localparam int Z_W          = 25;
  localparam int JD_OFFSET    = 2400001;
  localparam int GREG_START   = 2299161;
  // alpha = floor((4z - ALPHA_BIAS) / ALPHA_DIV), by reciprocal and one fixup
  localparam int ALPHA_BIAS   = 7468865;
  localparam int ALPHA_DIV    = 146097;
  localparam int ALPHA_RECIP  = 459;       // floor(2^26 / 146097)
  localparam int ALPHA_SHIFT  = 26;
  localparam int B_OFFSET     = 1524;
  // c = floor((20b - 2442) / 7305); numerator biased by C_BIAS * 7305
  localparam int C_BIAS       = 16400;
  localparam int X2_OFFSET    = 119799558; // C_BIAS * 7305 - 2442
  localparam int C_DIV        = 7305;
  localparam int C_RECIP      = 73493;     // floor(2^29 / 7305)
  localparam int C_SHIFT      = 29;
  localparam int D_MUL        = 1461;
  // e = floor(10000 (b - d) / 306001)
  localparam int E_NUM        = 10000;
  localparam int E_DIV        = 306001;
  localparam int E_RECIP      = 34267;     // floor(2^20 * 10000 / 306001)
  localparam int E_SHIFT      = 20;
  localparam int E_WRAP       = 14;
  localparam int FEB          = 2;
  localparam int YEAR_OFF_LATE  = 4716;
  localparam int YEAR_OFF_EARLY = 4715;
  // Leap test: divisibility by 25 on a biased, non-negative year
  localparam int Y_BIAS       = 25000;
  localparam int Y_DIV        = 25;
  localparam int Y_RECIP      = 83886;     // floor(2^21 / 25)
  localparam int Y_SHIFT      = 21;
  localparam int DOY_BIAS     = 30;

  // Time path
  localparam int SEC_PER_DAY  = 86400;
  localparam int NS_PER_SEC   = 1000000000;
  localparam int SECS_W       = 17;
  localparam int MDAY_W       = 11;
  localparam int SPROD_W      = FRAC_BITS + SECS_W;
  localparam int HPROD_W      = FRAC_BITS + 2;
  localparam int MPROD_W      = FRAC_BITS + 6;
  localparam int FRAC_LO_W    = FRAC_BITS / 2;
  localparam int FRAC_HI_W    = FRAC_BITS - FRAC_LO_W;
  localparam int PHI_W        = FRAC_HI_W + NS_W;
  localparam int PLO_W        = FRAC_LO_W + NS_W;
  localparam int NSUM_W       = FRAC_BITS + NS_W;

  // Time-of-day result carried down the delay stages
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [NS_W-1:0]   nanosecond;
  } tod_t;

  // floor(306001 * e / 10000)
  function automatic logic [8:0] e_days(input logic [3:0] e);
    case (e)
      4'd0:    return 9'd0;
      4'd1:    return 9'd30;
      4'd2:    return 9'd61;
      4'd3:    return 9'd91;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd183;
      4'd7:    return 9'd214;
      4'd8:    return 9'd244;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd336;
      4'd12:   return 9'd367;
      4'd13:   return 9'd397;
      4'd14:   return 9'd428;
      default: return 9'd459;
    endcase
  endfunction

  // floor(275 * m / 9)
  function automatic logic [8:0] month_days(input logic [3:0] m);
    case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd30;
      4'd2:    return 9'd61;
      4'd3:    return 9'd91;
      4'd4:    return 9'd122;
      4'd5:    return 9'd152;
      4'd6:    return 9'd183;
      4'd7:    return 9'd213;
      4'd8:    return 9'd244;
      4'd9:    return 9'd275;
      4'd10:   return 9'd305;
      4'd11:   return 9'd336;
      4'd12:   return 9'd366;
      4'd13:   return 9'd397;
      4'd14:   return 9'd427;
      default: return 9'd458;
    endcase
  endfunction

endpackage

// File: rtl/core/mjd_to_calendar_date_time_core.sv
// Throughput: one request per cycle while the output is not stalled, set by the 13-stage date pipeline.
// Empty stages fill under a stalled output, so requests keep entering
// until every stage holds an item.
// Reset clears the stage valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_time_core
// Modified Julian Day plus binary day fraction to calendar date and time of
// day, fully pipelined with valid/stall handshakes on both sides.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_time_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic signed [mdc_pkg::DAY_W-1:0]  day_number,
  input  logic [mdc_pkg::FRAC_IN_W-1:0]     day_fraction,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [mdc_pkg::YEAR_W-1:0] year,
  output logic [mdc_pkg::MONTH_W-1:0]       month,
  output logic [mdc_pkg::DOM_W-1:0]         day_of_month,
  output logic [mdc_pkg::DOY_W-1:0]         day_of_year,
  output logic [mdc_pkg::HOUR_W-1:0]        hour,
  output logic [mdc_pkg::MIN_W-1:0]         minute,
  output logic [mdc_pkg::SEC_W-1:0]         second,
  output logic [mdc_pkg::NS_W-1:0]          nanosecond
);
  import mdc_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] vld_next;
  logic [NSTAGE-1:0] adv;

  // A stage loads when it is empty or its contents move on
  assign adv[NSTAGE-1] = !vld[NSTAGE-1] || !res_stall;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_comb begin
    vld_next = vld;
    if (adv[0]) begin
      vld_next[0] = req_valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign req_stall = !adv[0];
  assign res_valid = vld[NSTAGE-1];

  mdc_date_pipe u_date (
    .clk          (clk),
    .adv          (adv),
    .day_number   (day_number),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .day_of_year  (day_of_year)
  );

  mdc_time_pipe u_time (
    .clk          (clk),
    .adv          (adv),
    .day_fraction (day_fraction),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .nanosecond   (nanosecond)
  );

endmodule

// File: rtl/core/mdc_date_pipe.sv
// ----------------------------------------------------------------------------
// mdc_date_pipe
// Thirteen-stage datapath from integer MJD to year, month, day of month and
// day of year. Constant divisions use a reciprocal estimate plus one fixup.
// ----------------------------------------------------------------------------
module mdc_date_pipe (
  input  logic                                clk,
  input  logic [mdc_pkg::NSTAGE-1:0]          adv,
  input  logic signed [mdc_pkg::DAY_W-1:0]    day_number,
  output logic signed [mdc_pkg::YEAR_W-1:0]   year,
  output logic [mdc_pkg::MONTH_W-1:0]         month,
  output logic [mdc_pkg::DOM_W-1:0]           day_of_month,
  output logic [mdc_pkg::DOY_W-1:0]           day_of_year
);
  import mdc_pkg::*;

  // Stage 1: julian day z, calendar select, alpha numerator
  logic signed [Z_W-1:0] z_next;
  logic signed [Z_W+1:0] x1_full;
  logic signed [Z_W-1:0] s1_z;
  logic                  s1_greg;
  logic [25:0]           s1_x1;

  always_comb begin
    z_next  = Z_W'(day_number) + Z_W'(JD_OFFSET);
    x1_full = ((Z_W+2)'(z_next) <<< 2) - (Z_W+2)'(ALPHA_BIAS);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_z    <= z_next;
      s1_greg <= (z_next >= Z_W'(GREG_START));
      s1_x1   <= x1_full[25:0];
    end
  end

  // Stage 2: alpha estimate
  logic [34:0]           q1_prod;
  logic [7:0]            s2_q1;
  logic [25:0]           s2_x1;
  logic signed [Z_W-1:0] s2_z;
  logic                  s2_greg;

  assign q1_prod = 35'(s1_x1) * 35'(ALPHA_RECIP);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_q1   <= q1_prod[ALPHA_SHIFT+7:ALPHA_SHIFT];
      s2_x1   <= s1_x1;
      s2_z    <= s1_z;
      s2_greg <= s1_greg;
    end
  end

  // Stage 3: alpha fixup
  logic [25:0]           q1_mul;
  logic [26:0]           r1;
  logic [7:0]            s3_alpha;
  logic signed [Z_W-1:0] s3_z;
  logic                  s3_greg;

  always_comb begin
    q1_mul = 26'(s2_q1) * 26'(ALPHA_DIV);
    r1     = 27'(s2_x1) - 27'(q1_mul);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_alpha <= s2_q1 + 8'(r1 >= 27'(ALPHA_DIV));
      s3_z     <= s2_z;
      s3_greg  <= s2_greg;
    end
  end

  // Stage 4: b = a + 1524
  logic signed [Z_W-1:0] a_greg;
  logic signed [Z_W-1:0] s4_b;

  assign a_greg = s3_z + Z_W'(1) + Z_W'(s3_alpha) - Z_W'(s3_alpha >> 2);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_b <= (s3_greg ? a_greg : s3_z) + Z_W'(B_OFFSET);
    end
  end

  // Stage 5: biased c numerator, always non-negative
  logic [29:0]           x2_full;
  logic [28:0]           s5_x2;
  logic signed [Z_W-1:0] s5_b;

  assign x2_full = (30'(s4_b) << 4) + (30'(s4_b) << 2) + 30'(X2_OFFSET);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_x2 <= x2_full[28:0];
      s5_b  <= s4_b;
    end
  end

  // Stage 6: c estimate
  logic [45:0]           q2_prod;
  logic [15:0]           s6_q2;
  logic [28:0]           s6_x2;
  logic signed [Z_W-1:0] s6_b;

  assign q2_prod = 46'(s5_x2) * 46'(C_RECIP);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_q2 <= q2_prod[C_SHIFT+15:C_SHIFT];
      s6_x2 <= s5_x2;
      s6_b  <= s5_b;
    end
  end

  // Stage 7: c fixup and bias removal
  logic [29:0]           r2;
  logic [16:0]           c_full;
  logic signed [15:0]    s7_c;
  logic signed [Z_W-1:0] s7_b;

  always_comb begin
    r2     = 30'(s6_x2) - 30'(30'(s6_q2) * 30'(C_DIV));
    c_full = 17'(s6_q2) + 17'(r2 >= 30'(C_DIV)) - 17'(C_BIAS);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_c <= c_full[15:0];
      s7_b <= s6_b;
    end
  end

  // Stage 8: d = floor(1461 c / 4), keep b - d (123..488)
  logic signed [27:0] d_prod;
  logic signed [25:0] bd_full;
  logic [8:0]         s8_bd;
  logic signed [15:0] s8_c;

  always_comb begin
    d_prod  = 28'(s7_c) * 28'(D_MUL);
    bd_full = 26'(s7_b) - 26'(d_prod >>> 2);
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_bd <= bd_full[8:0];
      s8_c  <= s7_c;
    end
  end

  // Stage 9: e estimate
  logic [24:0]        e_prod;
  logic [3:0]         s9_q3;
  logic [8:0]         s9_bd;
  logic signed [15:0] s9_c;

  assign e_prod = 25'(s8_bd) * 25'(E_RECIP);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s9_q3 <= e_prod[E_SHIFT+3:E_SHIFT];
      s9_bd <= s8_bd;
      s9_c  <= s8_c;
    end
  end

  // Stage 10: e fixup
  logic [23:0]        num3;
  logic [23:0]        sub3;
  logic [23:0]        r3;
  logic [3:0]         s10_e;
  logic [8:0]         s10_bd;
  logic signed [15:0] s10_c;

  always_comb begin
    num3 = 24'(s9_bd) * 24'(E_NUM);
    sub3 = 24'(s9_q3) * 24'(E_DIV);
    r3   = num3 - sub3;
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s10_e  <= s9_q3 + 4'(r3 >= 24'(E_DIV));
      s10_bd <= s9_bd;
      s10_c  <= s9_c;
    end
  end

  // Stage 11: day of month, month, year
  logic [8:0]         dom_full;
  logic [3:0]         month_next;
  logic signed [15:0] year_next;
  logic [4:0]         s11_dom;
  logic [3:0]         s11_month;
  logic signed [15:0] s11_year;

  always_comb begin
    dom_full   = s10_bd - e_days(s10_e);
    month_next = (s10_e < 4'(E_WRAP)) ? s10_e - 4'd1 : s10_e - 4'(E_WRAP - 1);
    year_next  = s10_c - ((month_next > 4'(FEB)) ? 16'(YEAR_OFF_LATE)
                                                  : 16'(YEAR_OFF_EARLY));
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      s11_dom   <= dom_full[4:0];
      s11_month <= month_next;
      s11_year  <= year_next;
    end
  end

  // Stage 12: year / 25 estimate on biased year
  logic [15:0]        u_next;
  logic [32:0]        y_prod;
  logic [10:0]        s12_q4;
  logic [15:0]        s12_u;
  logic [4:0]         s12_dom;
  logic [3:0]         s12_month;
  logic signed [15:0] s12_year;

  always_comb begin
    u_next = 16'(s11_year) + 16'(Y_BIAS);
    y_prod = 33'(u_next) * 33'(Y_RECIP);
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      s12_q4    <= y_prod[Y_SHIFT+10:Y_SHIFT];
      s12_u     <= u_next;
      s12_dom   <= s11_dom;
      s12_month <= s11_month;
      s12_year  <= s11_year;
    end
  end

  // Stage 13: leap test and day of year, output register
  logic [15:0] r4;
  logic        div25;
  logic        leap;
  logic [9:0]  doy_full;
  logic [9:0]  doy_adj;

  always_comb begin
    r4      = s12_u - 16'(16'(s12_q4) * 16'(Y_DIV));
    div25   = (r4 == 16'd0) || (r4 == 16'(Y_DIV));
    leap    = (s12_year[1:0] == 2'b00) && (!div25 || (s12_year[3:0] == 4'b0000));
    // Months after February lose two days, one in leap years
    doy_adj = (s12_month > 4'(FEB)) ? (leap ? 10'd1 : 10'd2) : 10'd0;
    doy_full = 10'(month_days(s12_month)) + 10'(s12_dom) - 10'(DOY_BIAS) - doy_adj;
  end

  always_ff @(posedge clk) begin
    if (adv[12]) begin
      year         <= s12_year;
      month        <= s12_month;
      day_of_month <= s12_dom;
      day_of_year  <= doy_full[DOY_W-1:0];
    end
  end

endmodule

// File: rtl/core/mdc_time_pipe.sv
// ----------------------------------------------------------------------------
// mdc_time_pipe
// Fraction of a day to hour, minute, second and rounded nanosecond in three
// stages, then a delay line to line up with the date path.
// ----------------------------------------------------------------------------
module mdc_time_pipe (
  input  logic                              clk,
  input  logic [mdc_pkg::NSTAGE-1:0]        adv,
  input  logic [mdc_pkg::FRAC_IN_W-1:0]     day_fraction,
  output logic [mdc_pkg::HOUR_W-1:0]        hour,
  output logic [mdc_pkg::MIN_W-1:0]         minute,
  output logic [mdc_pkg::SEC_W-1:0]         second,
  output logic [mdc_pkg::NS_W-1:0]          nanosecond
);
  import mdc_pkg::*;

  // Stage 1: seconds of day with remainder, hour and minute of day
  logic [FRAC_BITS-1:0] frac;
  logic [SPROD_W-1:0]   sec_prod;
  logic [HPROD_W-1:0]   hour_prod;
  logic [MPROD_W-1:0]   mday_prod;
  logic [SECS_W-1:0]    t1_secs;
  logic [FRAC_BITS-1:0] t1_rem;
  logic [HOUR_W-1:0]    t1_hour;
  logic [MDAY_W-1:0]    t1_mday;

  always_comb begin
    frac      = day_fraction[FRAC_BITS-1:0];
    sec_prod  = SPROD_W'(frac) * SPROD_W'(SEC_PER_DAY);
    hour_prod = HPROD_W'(frac) * HPROD_W'(3);   // 24 = 3 * 8
    mday_prod = MPROD_W'(frac) * MPROD_W'(45);  // 1440 = 45 * 32
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t1_secs <= sec_prod[SPROD_W-1:FRAC_BITS];
      t1_rem  <= sec_prod[FRAC_BITS-1:0];
      t1_hour <= hour_prod[HPROD_W-1:FRAC_BITS-3];
      t1_mday <= mday_prod[MPROD_W-1:FRAC_BITS-5];
    end
  end

  // Stage 2: remainder times 1e9 in two halves; minute and second
  logic [PHI_W-1:0]  p_hi;
  logic [PLO_W-1:0]  p_lo;
  logic [MDAY_W-1:0] hr60;
  logic [MDAY_W-1:0] min_full;
  logic [SECS_W-1:0] md60;
  logic [SECS_W-1:0] sec_full;
  logic [PHI_W-1:0]  t2_phi;
  logic [PLO_W-1:0]  t2_plo;
  logic [HOUR_W-1:0] t2_hour;
  logic [MIN_W-1:0]  t2_min;
  logic [SEC_W-1:0]  t2_sec;

  always_comb begin
    p_hi     = PHI_W'(t1_rem[FRAC_BITS-1:FRAC_LO_W]) * PHI_W'(NS_PER_SEC);
    p_lo     = PLO_W'(t1_rem[FRAC_LO_W-1:0]) * PLO_W'(NS_PER_SEC);
    hr60     = (MDAY_W'(t1_hour) << 6) - (MDAY_W'(t1_hour) << 2);
    min_full = t1_mday - hr60;
    md60     = (SECS_W'(t1_mday) << 6) - (SECS_W'(t1_mday) << 2);
    sec_full = t1_secs - md60;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      t2_phi  <= p_hi;
      t2_plo  <= p_lo;
      t2_hour <= t1_hour;
      t2_min  <= min_full[MIN_W-1:0];
      t2_sec  <= sec_full[SEC_W-1:0];
    end
  end

  // Stage 3: recombine halves, round half up, keep integer nanoseconds
  logic [NSUM_W-1:0] ns_sum;
  tod_t              tod_next;

  always_comb begin
    ns_sum = (NSUM_W'(t2_phi) << FRAC_LO_W) + NSUM_W'(t2_plo)
           + (NSUM_W'(1) << (FRAC_BITS - 1));
    tod_next.hour       = t2_hour;
    tod_next.minute     = t2_min;
    tod_next.second     = t2_sec;
    tod_next.nanosecond = ns_sum[NSUM_W-1:FRAC_BITS];
  end

  tod_t tq [TIME_LAST:NSTAGE-1];

  always_ff @(posedge clk) begin
    if (adv[TIME_LAST]) begin
      tq[TIME_LAST] <= tod_next;
    end
  end

  // Delay stages matching the date path
  for (genvar k = TIME_LAST + 1; k < NSTAGE; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        tq[k] <= tq[k-1];
      end
    end
  end

  assign hour       = tq[NSTAGE-1].hour;
  assign minute     = tq[NSTAGE-1].minute;
  assign second     = tq[NSTAGE-1].second;
  assign nanosecond = tq[NSTAGE-1].nanosecond;

endmodule

// File: tb/sv/mjd_to_calendar_date_time_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_time_core_tb
// Drives timestamps (MJD day number plus binary day fraction) into the core,
// predicts the calendar date and time of day for every accepted request and
// checks each result in order. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_time_core_tb;

  // One timestamp to send; drain holds it back until the core is empty
  typedef struct {
    logic signed [mdc_pkg::DAY_W-1:0] dn;
    logic [mdc_pkg::FRAC_IN_W-1:0]    df;
    bit                               drain;
  } stamp_t;

  // Calendar date and time of day as the core reports it
  typedef struct packed {
    logic signed [mdc_pkg::YEAR_W-1:0] yr;
    logic [mdc_pkg::MONTH_W-1:0]       mon;
    logic [mdc_pkg::DOM_W-1:0]         dom;
    logic [mdc_pkg::DOY_W-1:0]         doy;
    logic [mdc_pkg::HOUR_W-1:0]        hh;
    logic [mdc_pkg::MIN_W-1:0]         mm;
    logic [mdc_pkg::SEC_W-1:0]         ss;
    logic [mdc_pkg::NS_W-1:0]          ns;
  } date_time_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              req_valid = 1'b0;
  logic                              req_stall;
  logic signed [mdc_pkg::DAY_W-1:0]  day_number = '0;
  logic [mdc_pkg::FRAC_IN_W-1:0]     day_fraction = '0;
  logic                              res_valid;
  logic                              res_stall = 1'b0;
  logic signed [mdc_pkg::YEAR_W-1:0] year;
  logic [mdc_pkg::MONTH_W-1:0]       month;
  logic [mdc_pkg::DOM_W-1:0]         day_of_month;
  logic [mdc_pkg::DOY_W-1:0]         day_of_year;
  logic [mdc_pkg::HOUR_W-1:0]        hour;
  logic [mdc_pkg::MIN_W-1:0]         minute;
  logic [mdc_pkg::SEC_W-1:0]         second;
  logic [mdc_pkg::NS_W-1:0]          nanosecond;

  stamp_t     stamp_q[$];      // timestamps not yet offered
  date_time_t date_time_q[$];  // predicted results, oldest first

  int n_sent     = 0;          // accepted requests
  int n_done     = 0;          // results matched against a prediction
  int fail_count = 0;
  int gap_left   = 0;
  int stall_left = 0;
  bit calm       = 1'b0;       // tail of the run: no idling on either side

  mjd_to_calendar_date_time_core u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .day_number   (day_number),
    .day_fraction (day_fraction),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .day_of_year  (day_of_year),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .nanosecond   (nanosecond)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor division, divisor always positive
  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint greg_leap(input longint y);
    if (y % 4 != 0) return 0;
    if (y % 100 != 0) return 1;
    return (y % 400 == 0) ? 1 : 0;
  endfunction

  // Timestamp to calendar date (Meeus, integer form) and rounded time of day
  function automatic date_time_t mjd_to_date_time(
    input logic signed [mdc_pkg::DAY_W-1:0] dn,
    input logic [mdc_pkg::FRAC_IN_W-1:0]    df
  );
    date_time_t r;
    longint     z, a, alpha, b, c, d, e, dom, mon, yr, doy;
    logic [63:0] fmask, frac, sprod, secs;
    logic [79:0] nprod;
    fmask = (64'd1 << mdc_pkg::FRAC_BITS) - 64'd1;
    z = longint'(dn) + 2400001;
    if (z < 2299161) begin
      a = z;
    end else begin
      alpha = floor_quot(4 * z - 7468865, 146097);
      a = z + 1 + alpha - floor_quot(alpha, 4);
    end
    b   = a + 1524;
    c   = floor_quot(20 * b - 2442, 7305);
    d   = floor_quot(1461 * c, 4);
    e   = floor_quot(10000 * (b - d), 306001);
    dom = b - d - floor_quot(306001 * e, 10000);
    mon = (e < 14) ? e - 1 : e - 13;
    yr  = (mon > 2) ? c - 4716 : c - 4715;
    doy = floor_quot(275 * mon, 9) - (2 - greg_leap(yr)) * floor_quot(mon + 9, 12)
          + dom - 30;

    // Seconds of day, then the leftover fraction of a second in ns, half up
    frac  = {24'd0, df} & fmask;
    sprod = frac * 64'd86400;
    secs  = sprod >> mdc_pkg::FRAC_BITS;
    nprod = {16'd0, sprod & fmask} * 80'd1000000000
            + (80'd1 << (mdc_pkg::FRAC_BITS - 1));
    nprod = nprod >> mdc_pkg::FRAC_BITS;

    r.yr  = yr[mdc_pkg::YEAR_W-1:0];
    r.mon = mon[mdc_pkg::MONTH_W-1:0];
    r.dom = dom[mdc_pkg::DOM_W-1:0];
    r.doy = doy[mdc_pkg::DOY_W-1:0];
    r.hh  = 5'(secs / 64'd3600);
    r.mm  = 6'((secs / 64'd60) % 64'd60);
    r.ss  = 6'(secs % 64'd60);
    r.ns  = nprod[mdc_pkg::NS_W-1:0];
    return r;
  endfunction

  task automatic add_stamp(input int dn, input logic [39:0] df, input bit drain);
    stamp_t s;
    s.dn    = dn[mdc_pkg::DAY_W-1:0];
    s.df    = df;
    s.drain = drain;
    stamp_q.push_back(s);
  endtask

  // Day numbers: mostly the stated range, plus hot spots and the full field
  function automatic int rand_day();
    logic [31:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 9400000)) - 2400000;
      5: begin
        t = $urandom;
        return int'({{8{t[23]}}, t[23:0]});
      end
      6: return -100841 + int'($urandom_range(0, 100)) - 50;   // calendar switch
      7: return 51544 + int'($urandom_range(0, 800)) - 400;    // around 2000
      8: return -131009 + int'($urandom_range(0, 800)) - 400;  // Julian leap 1500
      default: return -2400001 + int'($urandom_range(0, 2000)) - 1000; // JD near 0
    endcase
  endfunction

  // Fractions: full random, near second boundaries, and both ends of the day
  function automatic logic [39:0] rand_frac();
    logic [63:0] t;
    longint      k;
    t = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1: begin
        k = longint'($urandom_range(0, 86399));
        k = ((k << 40) / 86400) + longint'($urandom_range(0, 3)) - 1;
        return k[39:0];
      end
      2: return 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 1000));
      3: return 40'($urandom_range(0, 1000));
      default: return t[39:0];
    endcase
  endfunction

  // Request driver
  always @(posedge clk) begin
    bit     took;
    stamp_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      gap_left  <= 0;
      calm      <= 1'b0;
    end else begin
      took = req_valid && !req_stall;
      if (took) begin
        date_time_q.push_back(mjd_to_date_time(day_number, day_fraction));
        n_sent <= n_sent + 1;
      end
      calm <= (stamp_q.size() <= 40);
      if (req_valid && !took) begin
        // stalled: hold the request as it is
      end else if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (stamp_q.size() == 0) begin
        req_valid <= 1'b0;
      end else if (stamp_q[0].drain && (took || n_sent != n_done)) begin
        req_valid <= 1'b0;
      end else if (stamp_q.size() > 40 && $urandom_range(0, 5) == 0) begin
        gap_left  <= $urandom_range(0, 4);
        req_valid <= 1'b0;
      end else begin
        nxt = stamp_q.pop_front();
        day_number   <= nxt.dn;
        day_fraction <= nxt.df;
        req_valid    <= 1'b1;
      end
    end
  end

  // Result monitor and output stall
  always @(posedge clk) begin
    date_time_t want, got;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        got = '{year, month, day_of_month, day_of_year, hour, minute, second, nanosecond};
        if (date_time_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("ERROR: result with no request pending: %0d-%0d-%0d", $signed(got.yr),
                     got.mon, got.dom);
        end else begin
          want = date_time_q.pop_front();
          n_done <= n_done + 1;
          if (want !== got) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("ERROR: result %0d exp %0d-%0d-%0d doy %0d %0d:%0d:%0d.%0d",
                       n_done, $signed(want.yr), want.mon, want.dom, want.doy,
                       want.hh, want.mm, want.ss, want.ns,
                       " got %0d-%0d-%0d doy %0d %0d:%0d:%0d.%0d",
                       $signed(got.yr), got.mon, got.dom, got.doy,
                       got.hh, got.mm, got.ss, got.ns);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        res_stall  <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // directed: field extremes, calendar switch, leap days, JD around zero
    add_stamp(0, 40'd0, 1'b0);
    add_stamp(-2400000, 40'd0, 1'b0);
    add_stamp(7000000, 40'hFF_FFFF_FFFF, 1'b0);   // last fraction step of the day
    add_stamp(-8388608, 40'hFF_FFFF_FFFF, 1'b0);
    add_stamp(8388607, 40'd0, 1'b0);
    add_stamp(-1, 40'h80_0000_0000, 1'b0);        // noon
    add_stamp(-1, 40'd1, 1'b0);
    add_stamp(-100841, 40'd1, 1'b0);              // last Julian day
    add_stamp(-100840, 40'hAA_AAAA_AAAA, 1'b0);   // first Gregorian day
    add_stamp(-2400001, 40'h55_5555_5555, 1'b0);
    add_stamp(-2400002, 40'h40_0000_0000, 1'b0);
    add_stamp(-4800000, 40'hC0_0000_0000, 1'b0);  // far Julian past
    add_stamp(51603, 40'h12_3456_789A, 1'b0);     // 2000 leap day
    add_stamp(51909, 40'hFE_DCBA_9876, 1'b0);     // day 366
    add_stamp(15078, 40'd1000, 1'b0);             // 1900, not leap
    add_stamp(15079, 40'd0, 1'b0);
    add_stamp(-131009, 40'h01_0000_0000, 1'b0);   // Julian-only leap day
    add_stamp(-131008, 40'd0, 1'b0);
    add_stamp(-130703, 40'hFF_FFFF_FF00, 1'b0);   // end of Julian leap year
    add_stamp(100000, 40'h00_0000_FFFF, 1'b1);    // sent once the core is empty
    for (int i = 0; i < 400; i++)
      add_stamp(rand_day(), rand_frac(), (i % 100) == 50);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (stamp_q.size() != 0 || req_valid) @(posedge clk);
    while (date_time_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && date_time_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mdc_pkg.sv
rtl/core/mdc_date_pipe.sv
rtl/core/mdc_time_pipe.sv
rtl/core/mjd_to_calendar_date_time_core.sv
tb/sv/mjd_to_calendar_date_time_core_tb.sv
